>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while reset is active.
`define SKIS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("sorted key set: assertion failed");

// Same check, written as an implication from a trigger.
`define SKIS_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
	`SKIS_ASSERT(lbl, clk, rst_n, (trig) |-> (cons))

`endif

>>> rtl/skis_pkg.sv
// Package: shared types and codes of the sorted key set.
`timescale 1ns / 1ps
package skis_pkg;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_CMP  = 1'b1
	} state_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic cmp_en;   // capture compare flags against the probe key
		logic write_en; // commit an insert: hold, take probe or take left key
	} cell_ctrl_t;

endpackage

>>> rtl/sorted_key_set_insert_lookup.sv
// Top level: sorted set of distinct keys held in a chain of compare-and-shift cells.
`timescale 1ns / 1ps
// Sorted key set with lookup and insert-if-absent. The keys sit in ascending
// order in a row of TABLE_DEPTH cells; a beat on the input channel carries an
// action (lookup, insert, clear; code 3 acts as a lookup) and a key. In the
// accept cycle each cell compares its key with the incoming one and registers
// less-than and equal flags; in the compare state the flags are encoded into
// the position, and on commit an insert moves every larger key one cell up
// while the insertion cell takes the new key. Each item yields exactly one
// result beat; the result register lets a new item be taken while the previous
// result waits, and the block only stalls in its compare state when the result
// register is still full and not being read. An insert into a full table is
// dropped with table_full set. No clearing pass is needed after reset: the
// occupied count starts at zero and cells above it are never read.
module sorted_key_set_insert_lookup #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BITS    = 31,
	localparam int POS_W      = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [KEY_BITS-1:0] key,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                found,
	output logic [POS_W-1:0]    position,
	output logic                inserted,
	output logic                table_full,
	output logic [POS_W-1:0]    stored_count
);

	skis_pkg::state_t    state_q, state_d;
	skis_pkg::action_t   action_q;
	logic [KEY_BITS-1:0] probe_q;
	logic [POS_W-1:0]    count_q;

	logic                in_beat;
	logic                commit;
	logic                is_insert;
	logic                is_clear;
	logic                has_room;
	logic                do_insert;
	skis_pkg::cell_ctrl_t ctrl;

	logic [TABLE_DEPTH-1:0] lt_vec;
	logic [TABLE_DEPTH-1:0] eq_vec;
	logic [KEY_BITS-1:0]    cell_key [TABLE_DEPTH];
	logic [POS_W-1:0]       enc_pos;
	logic                   enc_found;

	assign in_beat = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skis_pkg::ST_IDLE: begin
				if (in_beat) begin
					state_d = skis_pkg::ST_CMP;
				end
			end
			skis_pkg::ST_CMP: begin
				if (commit) begin
					state_d = skis_pkg::ST_IDLE;
				end
			end
			default: state_d = skis_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			skis_pkg::ST_IDLE: in_ready = 1'b1;
			// result lands once the output register is free or draining
			skis_pkg::ST_CMP:  commit = !out_valid || out_ready;
			default: begin
				in_ready = 1'b0;
				commit   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Held item for the commit cycle
	always_ff @(posedge clk) begin
		if (in_beat) begin
			action_q <= skis_pkg::action_t'(action);
			probe_q  <= key;
		end
	end

	// Action decode; unused code falls through as a lookup
	always_comb begin
		is_insert = 1'b0;
		is_clear  = 1'b0;
		unique case (action_q)
			skis_pkg::ACT_INSERT: is_insert = 1'b1;
			skis_pkg::ACT_CLEAR:  is_clear  = 1'b1;
			default: begin
				is_insert = 1'b0;
				is_clear  = 1'b0;
			end
		endcase
	end

	assign has_room  = (count_q != POS_W'(TABLE_DEPTH));
	assign do_insert = commit && is_insert && !enc_found && has_room;

	assign ctrl.cmp_en   = in_beat;
	assign ctrl.write_en = do_insert;

	// Cell chain: compare against the incoming key at accept, shift on insert
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] left_key;
		logic                left_lt;

		if (i == 0) begin : g_head
			assign left_key = probe_q;
			assign left_lt  = 1'b1;
		end else begin : g_body
			assign left_key = cell_key[i-1];
			assign left_lt  = lt_vec[i-1];
		end

		skis_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.probe_key (in_beat ? key : probe_q),
			.occupied  (POS_W'(i) < count_q),
			.left_key  (left_key),
			.left_lt   (left_lt),
			.key_q     (cell_key[i]),
			.lt_q      (lt_vec[i]),
			.eq_q      (eq_vec[i])
		);
	end

	skis_pos_enc #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.POS_W       (POS_W)
	) u_pos_enc (
		.lt    (lt_vec),
		.eq    (eq_vec),
		.pos   (enc_pos),
		.found (enc_found)
	);

	// Occupied count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit && is_clear) begin
			count_q <= '0;
		end else if (do_insert) begin
			count_q <= count_q + POS_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (is_clear) begin
				found        <= 1'b0;
				position     <= '0;
				inserted     <= 1'b0;
				table_full   <= 1'b0;
				stored_count <= '0;
			end else begin
				found        <= enc_found;
				position     <= enc_pos;
				inserted     <= do_insert;
				table_full   <= is_insert && !enc_found && !has_room;
				stored_count <= do_insert ? count_q + POS_W'(1) : count_q;
			end
		end
	end

endmodule

>>> rtl/skis_cell.sv
// One storage cell of the sorted key chain: key, compare flags, shift logic.
`timescale 1ns / 1ps
module skis_cell #(
	parameter int KEY_BITS = 31
) (
	input  logic                 clk,
	input  skis_pkg::cell_ctrl_t ctrl,
	input  logic [KEY_BITS-1:0]  probe_key,
	input  logic                 occupied,
	input  logic [KEY_BITS-1:0]  left_key,
	input  logic                 left_lt,
	output logic [KEY_BITS-1:0]  key_q,
	output logic                 lt_q,
	output logic                 eq_q
);

	// Flags only meaningful for occupied cells; empty cells read as not-less.
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= occupied && (key_q < probe_key);
			eq_q <= occupied && (key_q == probe_key);
		end
	end

	// Insert: smaller keys stay, the insertion cell takes the probe,
	// everything above takes its left neighbour.
	always_ff @(posedge clk) begin
		if (ctrl.write_en && !lt_q) begin
			if (left_lt) begin
				key_q <= probe_key;
			end else begin
				key_q <= left_key;
			end
		end
	end

endmodule

>>> rtl/skis_pos_enc.sv
// Position encoder: turns the less-than thermometer into an index, ORs matches.
`timescale 1ns / 1ps
module skis_pos_enc #(
	parameter int TABLE_DEPTH = 256,
	parameter int POS_W       = 9
) (
	input  logic [TABLE_DEPTH-1:0] lt,
	input  logic [TABLE_DEPTH-1:0] eq,
	output logic [POS_W-1:0]       pos,
	output logic                   found
);

	logic [TABLE_DEPTH-1:0] first_ge;

	// Sorted table: lt is a run of ones from cell 0; mark the first zero.
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (i == 0) begin
				first_ge[i] = !lt[i];
			end else begin
				first_ge[i] = !lt[i] && lt[i-1];
			end
		end
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (first_ge[i]) begin
				pos = pos | POS_W'(i);
			end
		end
		// every cell less than the key: position is the full depth
		if (&lt) begin
			pos = POS_W'(TABLE_DEPTH);
		end
	end

	assign found = |eq;

endmodule

>>> rtl/skis_checker.sv
// Port-level checker for the sorted key set, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module skis_checker #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BITS    = 31,
	localparam int POS_W      = $clog2(TABLE_DEPTH + 1)
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic [1:0]          action,
	input logic [KEY_BITS-1:0] key,
	input logic                out_valid,
	input logic                out_ready,
	input logic                found,
	input logic [POS_W-1:0]    position,
	input logic                inserted,
	input logic                table_full,
	input logic [POS_W-1:0]    stored_count
);

	`SKIS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	`SKIS_ASSERT_IMP(a_ins_excl, clk, arst_n, out_valid && inserted, !found && !table_full)
	`SKIS_ASSERT_IMP(a_full_count, clk, arst_n, out_valid && table_full, stored_count == POS_W'(TABLE_DEPTH))
	`SKIS_ASSERT_IMP(a_found_pos, clk, arst_n, out_valid && found, position < stored_count)
	`SKIS_ASSERT_IMP(a_ins_pos, clk, arst_n, out_valid && inserted, position < stored_count)

endmodule

bind sorted_key_set_insert_lookup skis_checker #(
	.TABLE_DEPTH (TABLE_DEPTH),
	.KEY_BITS    (KEY_BITS)
) u_skis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.action       (action),
	.key          (key),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.found        (found),
	.position     (position),
	.inserted     (inserted),
	.table_full   (table_full),
	.stored_count (stored_count)
);
